### hdl/nst_pkg.sv
// ---------------------------------------------------------------------------
// nst_pkg
// shared types and constants for the named semaphore table
// ---------------------------------------------------------------------------
package nst_pkg;

    localparam int SLOTS      = 16;
    localparam int NAME_BYTES = 8;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int KEY_W      = 64;
    localparam int CNT_W      = 16;
    localparam int HANDLE_W   = 4;

    typedef enum logic [2:0] {
        CMD_OPEN     = 3'd0,
        CMD_WAIT     = 3'd1,
        CMD_POST     = 3'd2,
        CMD_GETVALUE = 3'd3,
        CMD_UNLINK   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2,
        STS_EMPTY_KEY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_APPLY
    } state_t;

    // request fields broadcast to every cell
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [CNT_W-1:0]    init;
        logic [HANDLE_W-1:0] slot;
    } req_t;

    // decoded operation, already qualified by key and handle checks
    typedef struct packed {
        logic op_open;
        logic op_unlink;
        logic op_wait;
        logic op_post;
        logic op_get;
        logic any_match;
    } ops_t;

    // data handed from one cell to the next
    typedef struct packed {
        logic              found;
        logic              free;
        logic              hit;
        logic [SLOT_W-1:0] idx;
        logic [CNT_W-1:0]  val;
    } chain_t;

endpackage

### hdl/named_semaphore_table.sv
// ---------------------------------------------------------------------------
// named_semaphore_table
// table of named counting semaphores: open, wait, post, getvalue, unlink
// ---------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  ---------------------------------------------
//  request  in_valid / in_stall  cmd, name_key, init_value, slot, slot_valid
//  result   out_valid/out_stall  status, slot_out, value_out, must_block,
//                                wake_waiter
//
//  each transaction runs these steps in order: the accepting edge captures
//  and normalizes the key, the look state has every cell compare its name and
//  mark the first match along the chain, and the apply state picks the slot,
//  updates it and writes the result register
//  requests are taken one at a time; the next is accepted in the cycle after
//  the previous one has been written to the result register, even while that
//  result stalls
//  reset empties the table and clears every count at once, no clearing pass
//  a stalled result holds the update step until the result register frees up
//
module named_semaphore_table
    import nst_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [2:0]                 cmd,
    input  logic [KEY_W-1:0]           name_key,
    input  logic signed [CNT_W-1:0]    init_value,
    input  logic [HANDLE_W-1:0]        slot,
    input  logic                       slot_valid,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 status,
    output logic [HANDLE_W-1:0]        slot_out,
    output logic signed [CNT_W-1:0]    value_out,
    output logic                       must_block,
    output logic                       wake_waiter
);

    // keep the low name bytes up to the first zero byte
    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] res;
        logic             alive;
        res   = '0;
        alive = 1'b1;
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (k[8*b +: 8] == 8'h00)
            begin
                alive = 1'b0;
            end
            if (alive)
            begin
                res[8*b +: 8] = k[8*b +: 8];
            end
        end
        return res;
    endfunction

    state_t state_reg, state_next;

    // captured request
    logic [2:0]          cmd_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [CNT_W-1:0]    init_reg;
    logic [HANDLE_W-1:0] slot_reg;
    logic                slot_ok_reg;
    logic                key_zero_reg;
    logic                any_match_reg;

    // result register
    logic                       out_valid_reg, out_valid_next;
    logic [1:0]                 status_reg, status_next;
    logic [HANDLE_W-1:0]        slot_out_reg, slot_out_next;
    logic signed [CNT_W-1:0]    value_reg, value_next;
    logic                       block_reg, block_next;
    logic                       wake_reg, wake_next;

    logic                 accept;
    logic                 look_en;
    logic                 apply_en;
    logic [KEY_W-1:0]     key_norm;
    logic [SLOT_W+3:0]    slot_wide;
    logic                 slot_ok;
    logic [SLOT_W+3:0]    hit_idx_wide;
    logic signed [CNT_W-1:0] tail_val;
    req_t                 req;
    ops_t                 ops;
    chain_t               tail;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign key_norm  = norm_key(name_key);
    assign slot_wide = {{SLOT_W{1'b0}}, slot};
    assign slot_ok   = slot_valid && (slot_wide < (SLOT_W+4)'(SLOTS));

    // broadcast to the cells; name commands with an empty key do nothing
    assign req.key  = key_reg;
    assign req.init = init_reg;
    assign req.slot = slot_reg;

    assign ops.op_open   = (cmd_reg == CMD_OPEN) && !key_zero_reg;
    assign ops.op_unlink = (cmd_reg == CMD_UNLINK) && !key_zero_reg;
    assign ops.op_wait   = (cmd_reg == CMD_WAIT) && slot_ok_reg;
    assign ops.op_post   = (cmd_reg == CMD_POST) && slot_ok_reg;
    assign ops.op_get    = (cmd_reg == CMD_GETVALUE) && slot_ok_reg;
    assign ops.any_match = any_match_reg;

    nst_row u_row (
        .clk      (clk),
        .rst_n    (rst_n),
        .look_en  (look_en),
        .apply_en (apply_en),
        .req      (req),
        .ops      (ops),
        .tail     (tail)
    );

    assign hit_idx_wide = {4'b0, tail.idx};
    assign tail_val     = tail.val;

    // sequencer and result formation
    always_comb
    begin
        state_next     = state_reg;
        look_en        = 1'b0;
        apply_en       = 1'b0;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        slot_out_next  = slot_out_reg;
        value_next     = value_reg;
        block_next     = block_reg;
        wake_next      = wake_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                look_en    = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    apply_en       = 1'b1;
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = STS_OK;
                    slot_out_next  = '0;
                    value_next     = '0;
                    block_next     = 1'b0;
                    wake_next      = 1'b0;
                    case (cmd_reg) inside
                        CMD_OPEN, CMD_UNLINK:
                        begin
                            if (key_zero_reg)
                            begin
                                status_next = STS_EMPTY_KEY;
                            end
                            else if (!tail.hit)
                            begin
                                status_next = (cmd_reg == CMD_OPEN) ? STS_FULL
                                                                    : STS_NOT_FOUND;
                            end
                            else
                            begin
                                slot_out_next = hit_idx_wide[HANDLE_W-1:0];
                                value_next    = tail_val;
                            end
                        end
                        CMD_WAIT, CMD_POST, CMD_GETVALUE:
                        begin
                            if (!slot_ok_reg)
                            begin
                                status_next = STS_NOT_FOUND;
                                value_next  = -CNT_W'(1);
                            end
                            else
                            begin
                                slot_out_next = slot_reg;
                                value_next    = tail_val;
                                block_next    = (cmd_reg == CMD_WAIT) && (tail_val < 0);
                                wake_next     = (cmd_reg == CMD_POST) && (tail_val <= 0);
                            end
                        end
                        default:
                        begin
                            status_next = STS_NOT_FOUND;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            any_match_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (look_en)
            begin
                any_match_reg <= tail.found;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= cmd;
            key_reg      <= key_norm;
            init_reg     <= init_value;
            slot_reg     <= slot;
            slot_ok_reg  <= slot_ok;
            key_zero_reg <= (key_norm == '0);
        end
        status_reg   <= status_next;
        slot_out_reg <= slot_out_next;
        value_reg    <= value_next;
        block_reg    <= block_next;
        wake_reg     <= wake_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot_out    = slot_out_reg;
    assign value_out   = value_reg;
    assign must_block  = block_reg;
    assign wake_waiter = wake_reg;

endmodule

### hdl/nst_cell.sv
// ---------------------------------------------------------------------------
// nst_cell
// one semaphore slot: name, count and used flag, plus its link of the chain
// ---------------------------------------------------------------------------
module nst_cell
    import nst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              look_en,
    input  logic              apply_en,
    input  req_t              req,
    input  ops_t              ops,
    input  logic [SLOT_W-1:0] idx,
    input  chain_t            cin,
    output chain_t            cout
);

    logic                    used_reg;
    logic [KEY_W-1:0]        name_reg;
    logic signed [CNT_W-1:0] count_reg;
    logic                    first_reg;

    logic                    match;
    logic                    first_free;
    logic                    handle_hit;
    logic                    selected;
    logic                    create;
    logic [SLOT_W+3:0]       idx_wide;
    logic signed [CNT_W-1:0] count_new;

    assign idx_wide   = {4'b0, idx};
    assign match      = used_reg && (name_reg == req.key);
    assign first_free = !used_reg && !cin.free;
    assign handle_hit = (idx_wide[SLOT_W+3:HANDLE_W] == '0)
                        && (idx_wide[HANDLE_W-1:0] == req.slot);
    assign create     = ops.op_open && !ops.any_match;

    assign selected = (ops.op_open && (ops.any_match ? first_reg : first_free))
                      || (ops.op_unlink && ops.any_match && first_reg)
                      || ((ops.op_wait || ops.op_post || ops.op_get) && handle_hit);

    always_comb
    begin
        count_new = count_reg;
        if (create)
        begin
            count_new = req.init;
        end
        else if (ops.op_unlink)
        begin
            count_new = '0;
        end
        else if (ops.op_wait)
        begin
            // saturate at the most negative count
            if (count_reg != {1'b1, {(CNT_W-1){1'b0}}})
            begin
                count_new = count_reg - CNT_W'(1);
            end
        end
        else if (ops.op_post)
        begin
            if (count_reg != {1'b0, {(CNT_W-1){1'b1}}})
            begin
                count_new = count_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        cout.found = cin.found || match;
        cout.free  = cin.free || !used_reg;
        cout.hit   = cin.hit || selected;
        cout.idx   = cin.idx | (selected ? idx : '0);
        cout.val   = cin.val | (selected ? count_new : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            count_reg <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            if (look_en)
            begin
                first_reg <= match && !cin.found;
            end
            if (apply_en && selected)
            begin
                count_reg <= count_new;
                if (create)
                begin
                    used_reg <= 1'b1;
                end
                else if (ops.op_unlink)
                begin
                    used_reg <= 1'b0;
                end
            end
        end
    end

    // names carry no reset, only compared while the slot is in use
    always_ff @(posedge clk)
    begin
        if (apply_en && selected && create)
        begin
            name_reg <= req.key;
        end
    end

endmodule

### hdl/nst_row.sv
// ---------------------------------------------------------------------------
// nst_row
// row of slot cells linked into one priority and read-back chain
// ---------------------------------------------------------------------------
module nst_row
    import nst_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   look_en,
    input  logic   apply_en,
    input  req_t   req,
    input  ops_t   ops,
    output chain_t tail
);

    chain_t links [SLOTS+1];

    assign links[0] = '0;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        nst_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .look_en  (look_en),
            .apply_en (apply_en),
            .req      (req),
            .ops      (ops),
            .idx      (SLOT_W'(g)),
            .cin      (links[g]),
            .cout     (links[g+1])
        );
    end

    assign tail = links[SLOTS];

endmodule

### tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the named semaphore table
// ---------------------------------------------------------------------------
//
//  a short directed table runs first: an untouched table, null handles, empty
//  keys, unknown commands, count saturation at both ends, open of an existing
//  name and of a name with junk past its terminating zero byte, unlink
//  then a random mix over a small pool of names, so that opens hit existing
//  slots, the table fills up and unlink frees slots again
//  every accepted request is run through a local copy of the table, and each
//  result transaction is compared with the oldest pending prediction
//  the sender works in bursts, the receiver stalls on a pattern of its own and
//  once holds off long enough to back the block up into its request port
//
module tb_top;

    import nst_pkg::*;

    // command codes with no operation behind them
    localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;

    localparam int CNT_MAX = 2 ** (CNT_W - 1) - 1;
    localparam int CNT_MIN = -(2 ** (CNT_W - 1));

    localparam logic [CNT_W-1:0] INIT_MIN = 16'h8000;
    localparam logic [CNT_W-1:0] INIT_MAX = 16'h7FFF;

    // names used by the directed table
    localparam logic [KEY_W-1:0] NAME_NONE     = '0;
    localparam logic [KEY_W-1:0] NAME_ALL_ONES = '1;
    localparam logic [KEY_W-1:0] NAME_LOW_ZERO = 64'hFFFF_FFFF_FFFF_FF00;
    localparam logic [KEY_W-1:0] NAME_ABSENT   = 64'h0000_0000_0043_4241;
    localparam logic [KEY_W-1:0] NAME_A        = 64'h0000_0000_0000_0041;
    localparam logic [KEY_W-1:0] NAME_A_ALIAS  = 64'h5A5A_5A00_0000_0041;
    localparam logic [KEY_W-1:0] NAME_SEQ      = 64'h0102_0304_0506_0708;

    localparam int RANDOM_ITEMS    = 625;
    localparam int POOL_NAMES      = 20;
    localparam int HOLD_OFF_AT     = 60;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef struct packed {
        logic [2:0]          cmd;
        logic [KEY_W-1:0]    key;
        logic [CNT_W-1:0]    init;
        logic [HANDLE_W-1:0] slot;
        logic                slot_valid;
    } sem_req_t;

    typedef struct packed {
        status_t                 status;
        logic [HANDLE_W-1:0]     slot_out;
        logic signed [CNT_W-1:0] value;
        logic                    must_block;
        logic                    wake_waiter;
    } sem_result_t;

    // fixed_want set: the row carries its own answer, else the answer is computed
    typedef struct packed {
        sem_req_t    req;
        logic        fixed_want;
        sem_result_t want;
    } stim_row_t;

    localparam sem_result_t CALC = '0;

    localparam stim_row_t DIRECTED_ROWS [25] = '{
        // untouched table, highest handle
        '{'{CMD_GETVALUE, NAME_NONE, 16'h0000, 4'd15, 1'b1},
          1'b1, '{STS_OK, 4'd15, 16'h0000, 1'b0, 1'b0}},
        // wait and post on a free slot act on its count, which starts at zero
        '{'{CMD_WAIT, NAME_NONE, 16'h0000, 4'd0, 1'b1},
          1'b1, '{STS_OK, 4'd0, 16'hFFFF, 1'b1, 1'b0}},
        '{'{CMD_POST, NAME_NONE, 16'h0000, 4'd0, 1'b1},
          1'b1, '{STS_OK, 4'd0, 16'h0000, 1'b0, 1'b1}},
        // null handles
        '{'{CMD_GETVALUE, NAME_ALL_ONES, 16'hFFFF, 4'd15, 1'b0},
          1'b1, '{STS_NOT_FOUND, 4'd0, 16'hFFFF, 1'b0, 1'b0}},
        '{'{CMD_WAIT, NAME_NONE, 16'h0000, 4'd3, 1'b0},
          1'b1, '{STS_NOT_FOUND, 4'd0, 16'hFFFF, 1'b0, 1'b0}},
        '{'{CMD_POST, NAME_NONE, 16'h0000, 4'd3, 1'b0},
          1'b1, '{STS_NOT_FOUND, 4'd0, 16'hFFFF, 1'b0, 1'b0}},
        // empty keys, including one that ends at its first byte
        '{'{CMD_OPEN, NAME_NONE, INIT_MAX, 4'd0, 1'b1},
          1'b1, '{STS_EMPTY_KEY, 4'd0, 16'h0000, 1'b0, 1'b0}},
        '{'{CMD_UNLINK, NAME_NONE, 16'h0000, 4'd0, 1'b1},
          1'b1, '{STS_EMPTY_KEY, 4'd0, 16'h0000, 1'b0, 1'b0}},
        '{'{CMD_OPEN, NAME_LOW_ZERO, 16'h0005, 4'd0, 1'b1},
          1'b1, '{STS_EMPTY_KEY, 4'd0, 16'h0000, 1'b0, 1'b0}},
        // unlink of a name that is not there
        '{'{CMD_UNLINK, NAME_ABSENT, 16'h0000, 4'd0, 1'b1},
          1'b1, '{STS_NOT_FOUND, 4'd0, 16'h0000, 1'b0, 1'b0}},
        // saturation at the bottom
        '{'{CMD_OPEN, NAME_ALL_ONES, INIT_MIN, 4'd0, 1'b1}, 1'b0, CALC},
        '{'{CMD_WAIT, NAME_NONE, 16'h0000, 4'd0, 1'b1}, 1'b0, CALC},
        // saturation at the top
        '{'{CMD_OPEN, NAME_A, INIT_MAX, 4'd0, 1'b1}, 1'b0, CALC},
        '{'{CMD_POST, NAME_NONE, 16'h0000, 4'd1, 1'b1}, 1'b0, CALC},
        // existing name, then the same name with junk past its end
        '{'{CMD_OPEN, NAME_A, 16'h0005, 4'd0, 1'b1}, 1'b0, CALC},
        '{'{CMD_OPEN, NAME_A_ALIAS, 16'h0000, 4'd0, 1'b1}, 1'b0, CALC},
        // full-length name, count walked across zero both ways
        '{'{CMD_OPEN, NAME_SEQ, 16'h0001, 4'd0, 1'b1}, 1'b0, CALC},
        '{'{CMD_WAIT, NAME_NONE, 16'h0000, 4'd2, 1'b1}, 1'b0, CALC},
        '{'{CMD_WAIT, NAME_NONE, 16'h0000, 4'd2, 1'b1}, 1'b0, CALC},
        '{'{CMD_POST, NAME_NONE, 16'h0000, 4'd2, 1'b1}, 1'b0, CALC},
        '{'{CMD_POST, NAME_NONE, 16'h0000, 4'd2, 1'b1}, 1'b0, CALC},
        // unlink clears the count of the freed slot
        '{'{CMD_UNLINK, NAME_A, 16'h0000, 4'd0, 1'b1}, 1'b0, CALC},
        '{'{CMD_GETVALUE, NAME_NONE, 16'h0000, 4'd1, 1'b1}, 1'b0, CALC},
        // unknown commands
        '{'{CMD_RSVD_FIRST, NAME_SEQ, 16'h0001, 4'd2, 1'b1},
          1'b1, '{STS_NOT_FOUND, 4'd0, 16'h0000, 1'b0, 1'b0}},
        '{'{CMD_RSVD_LAST, NAME_ALL_ONES, INIT_MAX, 4'd15, 1'b1},
          1'b1, '{STS_NOT_FOUND, 4'd0, 16'h0000, 1'b0, 1'b0}}
    };

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [2:0]              cmd;
    logic [KEY_W-1:0]        name_key;
    logic signed [CNT_W-1:0] init_value;
    logic [HANDLE_W-1:0]     slot;
    logic                    slot_valid;
    logic                    out_valid;
    logic                    out_stall;
    logic [1:0]              status;
    logic [HANDLE_W-1:0]     slot_out;
    logic signed [CNT_W-1:0] value_out;
    logic                    must_block;
    logic                    wake_waiter;

    // local copy of the semaphore table
    logic                    sem_used  [SLOTS];
    logic [KEY_W-1:0]        tbl_key   [SLOTS];
    logic signed [CNT_W-1:0] sem_count [SLOTS];

    sem_result_t pending_results [$];

    logic [KEY_W-1:0] name_pool [POOL_NAMES];
    int               pool_len  [POOL_NAMES];

    int fail_count     = 0;
    int accepted_items = 0;
    int burst_left     = 0;

    named_semaphore_table u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .name_key    (name_key),
        .init_value  (init_value),
        .slot        (slot),
        .slot_valid  (slot_valid),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .slot_out    (slot_out),
        .value_out   (value_out),
        .must_block  (must_block),
        .wake_waiter (wake_waiter)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // name as the table sees it: low NAME_BYTES bytes, cut at the first zero byte
    function automatic logic [KEY_W-1:0] trim_name(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] name;
        bit               ended;
        name  = '0;
        ended = 1'b0;
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (raw[8*b +: 8] == 8'h00)
                ended = 1'b1;
            if (!ended)
                name[8*b +: 8] = raw[8*b +: 8];
        end
        return name;
    endfunction

    // applies one request to the local table and returns the answer it gives
    function automatic sem_result_t apply_request(input sem_req_t r);
        sem_result_t      res;
        logic [KEY_W-1:0] name;
        int               hit;
        int               free_slot;
        int               cnt;
        res       = '0;
        name      = trim_name(r.key);
        hit       = -1;
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (sem_used[i] && tbl_key[i] == name && hit < 0)
                hit = i;
            if (!sem_used[i] && free_slot < 0)
                free_slot = i;
        end
        case (r.cmd) inside
            CMD_OPEN, CMD_UNLINK:
            begin
                if (name == '0)
                    res.status = STS_EMPTY_KEY;
                else if (r.cmd == CMD_OPEN)
                begin
                    // an existing name keeps its count, init is ignored
                    if (hit < 0 && free_slot >= 0)
                    begin
                        hit            = free_slot;
                        sem_used[hit]  = 1'b1;
                        tbl_key[hit]   = name;
                        sem_count[hit] = r.init;
                    end
                    if (hit < 0)
                        res.status = STS_FULL;
                    else
                    begin
                        res.slot_out = hit[HANDLE_W-1:0];
                        res.value    = sem_count[hit];
                    end
                end
                else if (hit < 0)
                    res.status = STS_NOT_FOUND;
                else
                begin
                    sem_used[hit]  = 1'b0;
                    tbl_key[hit]   = '0;
                    sem_count[hit] = '0;
                    res.slot_out   = hit[HANDLE_W-1:0];
                end
            end
            CMD_WAIT, CMD_POST, CMD_GETVALUE:
            begin
                if (!r.slot_valid || int'(r.slot) >= SLOTS)
                begin
                    res.status = STS_NOT_FOUND;
                    res.value  = CNT_W'(-1);
                end
                else
                begin
                    cnt = int'(sem_count[r.slot]);
                    if (r.cmd == CMD_WAIT)
                        cnt = cnt - 1;
                    else if (r.cmd == CMD_POST)
                        cnt = cnt + 1;
                    if (cnt > CNT_MAX)
                        cnt = CNT_MAX;
                    if (cnt < CNT_MIN)
                        cnt = CNT_MIN;
                    sem_count[r.slot] = cnt[CNT_W-1:0];
                    res.slot_out      = r.slot;
                    res.value         = cnt[CNT_W-1:0];
                    res.must_block    = (r.cmd == CMD_WAIT) && (cnt < 0);
                    res.wake_waiter   = (r.cmd == CMD_POST) && (cnt <= 0);
                end
            end
            default:
                res.status = STS_NOT_FOUND;
        endcase
        return res;
    endfunction

    // a pool name, now and then with junk above its terminating zero byte
    function automatic logic [KEY_W-1:0] pool_key();
        int               p;
        logic [KEY_W-1:0] junk;
        p    = $urandom_range(0, POOL_NAMES - 1);
        junk = {$urandom, $urandom};
        if (pool_len[p] <= NAME_BYTES - 2 && $urandom_range(0, 3) == 0)
            return name_pool[p] | (junk << (8 * (pool_len[p] + 1)));
        return name_pool[p];
    endfunction

    function automatic sem_req_t random_request();
        sem_req_t r;
        int       pick;
        r.cmd        = CMD_GETVALUE;
        r.key        = {$urandom, $urandom};
        r.slot       = HANDLE_W'($urandom_range(0, SLOTS - 1));
        r.slot_valid = ($urandom_range(0, 15) != 0);
        // counts stay near zero mostly, with the extremes mixed in
        case ($urandom_range(0, 7))
            0:       r.init = INIT_MIN;
            1:       r.init = INIT_MAX;
            2:       r.init = 16'hFFFF;
            3:       r.init = 16'h0000;
            4:       r.init = 16'h0001;
            5, 6:    r.init = 16'($urandom_range(0, 8) - 4);
            default: r.init = 16'($urandom);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            r.cmd = CMD_OPEN;
            r.key = pool_key();
        end
        else if (pick < 50)
            r.cmd = CMD_WAIT;
        else if (pick < 70)
            r.cmd = CMD_POST;
        else if (pick < 78)
            r.cmd = CMD_GETVALUE;
        else if (pick < 90)
        begin
            r.cmd = CMD_UNLINK;
            r.key = pool_key();
        end
        else
        begin
            // noise: empty keys, unknown codes, stray names, null handles
            case (pick % 5)
                0:
                begin
                    r.cmd = ($urandom_range(0, 1) != 0) ? CMD_OPEN : CMD_UNLINK;
                    r.key = r.key & ~64'hFF;
                end
                1:       r.cmd = 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
                2:       r.cmd = CMD_OPEN;
                3:       r.cmd = CMD_UNLINK;
                default:
                begin
                    r.cmd        = 3'($urandom_range(CMD_WAIT, CMD_GETVALUE));
                    r.slot_valid = 1'b0;
                end
            endcase
        end
        return r;
    endfunction

    // offers one request transaction and records its answer once accepted
    task automatic issue_request(input sem_req_t r, input logic fixed_want,
                                 input sem_result_t want);
        sem_result_t predicted;
        // gap between bursts; a long burst now and then runs with no idling
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        in_valid   <= 1'b1;
        cmd        <= r.cmd;
        name_key   <= r.key;
        init_value <= r.init;
        slot       <= r.slot;
        slot_valid <= r.slot_valid;
        do
            @(posedge clk);
        while (in_stall);
        predicted = apply_request(r);
        pending_results.push_back(fixed_want ? want : predicted);
        accepted_items++;
    endtask

    // main stimulus
    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        cmd        <= CMD_OPEN;
        name_key   <= '0;
        init_value <= '0;
        slot       <= '0;
        slot_valid <= 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            sem_used[i]  = 1'b0;
            tbl_key[i]   = '0;
            sem_count[i] = '0;
        end
        // more names than slots, so that open can find the table full
        for (int p = 0; p < POOL_NAMES; p++)
        begin
            pool_len[p]  = $urandom_range(1, NAME_BYTES);
            name_pool[p] = '0;
            for (int b = 0; b < pool_len[p]; b++)
                name_pool[p][8*b +: 8] = 8'($urandom_range(1, 255));
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < $size(DIRECTED_ROWS); n++)
            issue_request(DIRECTED_ROWS[n].req, DIRECTED_ROWS[n].fixed_want,
                          DIRECTED_ROWS[n].want);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            issue_request(random_request(), 1'b0, CALC);
        in_valid <= 1'b0;

        // let every result drain, then watch a little longer for strays
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // result side: checks each accepted transaction and drives the stall
    initial
    begin
        int          mode;
        int          mode_left;
        int          hold_left;
        bit          hold_done;
        sem_result_t got;
        sem_result_t want;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got = '{status_t'(status), slot_out, value_out, must_block, wake_waiter};
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with nothing pending: status %0d slot %0d",
                             $realtime, got.status, got.slot_out);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        $display("%0t: mismatch: expected status %0d slot %0d value %0d",
                                 $realtime, want.status, want.slot_out, want.value,
                                 " block %0b wake %0b, got status %0d slot %0d",
                                 want.must_block, want.wake_waiter, got.status,
                                 got.slot_out, " value %0d block %0b wake %0b",
                                 got.value, got.must_block, got.wake_waiter);
                    end
                end
            end

            // one long hold-off so the block backs up into its request port
            if (!hold_done && accepted_items >= HOLD_OFF_AT)
            begin
                hold_left = HOLD_OFF_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // watchdog: too long with no transaction on either side ends the run
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
